// ----- hdl/tclp_pkg.sv -----
// ----------------------------------------------------------------------------
// Time code line parser package
// Shared widths, character codes, the line template and column helpers.
// ----------------------------------------------------------------------------
package tclp_pkg;

   localparam int BYTE_W     = 8;
   localparam int NUM_W      = 7;
   localparam int TZ_W       = 5;
   localparam int ATT_W      = 8;
   localparam int COL_W      = 6;
   localparam int SLOT_W     = 4;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   localparam int LINE_LEN       = 52;
   localparam int DIGIT_SLOTS    = 14;
   localparam int FLUSH_ECHO_MAX = 54;

   localparam logic [COL_W-1:0] LAST_COL  = COL_W'(LINE_LEN - 1);
   localparam logic [COL_W-1:0] FLUSH_MAX = COL_W'(FLUSH_ECHO_MAX);

   localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RST = 8'd11;
   localparam logic [TZ_W-1:0]  TZ_WEST_RST      = '0;

   // Daylight-saving indicator codes (two digits of the line)
   localparam logic [NUM_W-1:0] DST_OFF    = 7'd0;
   localparam logic [NUM_W-1:0] DST_ALL_ON = 7'd50;
   localparam logic [NUM_W-1:0] DST_SPRING = 7'd51;
   localparam logic [NUM_W-1:0] DST_FALL   = 7'd1;

   // Character codes
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;
   localparam logic [BYTE_W-1:0] CH_J     = 8'h4A;
   localparam logic [BYTE_W-1:0] CH_D     = 8'h44;

   // '#' is any digit, '+' is a sign, the last column is '*' or '#'
   localparam logic [LINE_LEN*BYTE_W-1:0] LINE_TMPL =
      "\r\n##### ##-##-## ##:##:## ## # +.# ###.# UTC(NIST) *";

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TZ_WEST      = 1'b0,
      CSR_MAX_ATTEMPTS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] idx;
   } slot_sel_type;

   function automatic logic [BYTE_W-1:0] tmpl_char(input logic [COL_W-1:0] col);
      int pos;
      pos = LINE_LEN - 1 - int'(col);
      return LINE_TMPL[pos*BYTE_W +: BYTE_W];
   endfunction

   // Digit slot of a column: year, month, day, hour, minute, second, DST
   function automatic slot_sel_type digit_slot(input logic [COL_W-1:0] col);
      slot_sel_type s;
      s.hit = 1'b1;
      unique case (col)
         6'd8:    s.idx = 4'd0;
         6'd9:    s.idx = 4'd1;
         6'd11:   s.idx = 4'd2;
         6'd12:   s.idx = 4'd3;
         6'd14:   s.idx = 4'd4;
         6'd15:   s.idx = 4'd5;
         6'd17:   s.idx = 4'd6;
         6'd18:   s.idx = 4'd7;
         6'd20:   s.idx = 4'd8;
         6'd21:   s.idx = 4'd9;
         6'd23:   s.idx = 4'd10;
         6'd24:   s.idx = 4'd11;
         6'd26:   s.idx = 4'd12;
         6'd27:   s.idx = 4'd13;
         default: begin
            s.hit = 1'b0;
            s.idx = '0;
         end
      endcase
      return s;
   endfunction

   // Ten times the high digit plus the low digit, kept to 7 bits
   function automatic logic [NUM_W-1:0] pair_val(input logic [SLOT_W-1:0] hi,
                                                 input logic [SLOT_W-1:0] lo);
      logic [BYTE_W-1:0] sum;
      sum = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
      return sum[NUM_W-1:0];
   endfunction

endpackage

// ----- hdl/tclp_if.sv -----
// ----------------------------------------------------------------------------
// Time code line parser channels
// Valid/ready channels for received bytes and for parse results.
// ----------------------------------------------------------------------------
interface tclp_req_if import tclp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tclp_rsp_if import tclp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              echo_valid;
   logic [BYTE_W-1:0] echo_byte;
   logic              frame_valid;
   logic              failed;
   logic [NUM_W-1:0]  year_2d;
   logic [NUM_W-1:0]  month_num;
   logic [NUM_W-1:0]  day_num;
   logic [NUM_W-1:0]  hour_num;
   logic [NUM_W-1:0]  minute_num;
   logic [NUM_W-1:0]  second_num;
   logic              dst_active;
   logic              synced;

   modport source (output valid, output echo_valid, output echo_byte,
                   output frame_valid, output failed, output year_2d,
                   output month_num, output day_num, output hour_num,
                   output minute_num, output second_num, output dst_active,
                   output synced, input ready);
   modport sink   (input valid, input echo_valid, input echo_byte,
                   input frame_valid, input failed, input year_2d,
                   input month_num, input day_num, input hour_num,
                   input minute_num, input second_num, input dst_active,
                   input synced, output ready);
endinterface

// ----- hdl/time_code_line_parser.sv -----
// ----------------------------------------------------------------------------
// Time code line parser
// Hunts for the MJD literal, checks 52-byte time lines against the template,
// echoes line bytes and reports the date, time and daylight-saving decision.
// ----------------------------------------------------------------------------
// The result of a transaction sits in the output register in the cycle after
//   the byte is accepted.
// Throughput: 1 byte per cycle unless responses stall; parse state advances
//   once per accepted byte, output register refills while the old one leaves.
// Reset (synchronous, active high): hunt for MJD, tz_west_hours = 0,
//   max_attempts = 11, output register empty. Digit store is not cleared.
module time_code_line_parser import tclp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tclp_req_if.sink              req_chan,
   tclp_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_LINE  = 2'd1,
      PH_FLUSH = 2'd2
   } phase_type;

   // Configuration registers
   logic signed [TZ_W-1:0] tz_west_ff;
   logic [ATT_W-1:0]       max_att_ff;

   // Parse state
   phase_type         phase_ff, phase_in;
   logic [1:0]        prog_ff, prog_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  fcnt_ff, fcnt_in;
   logic [ATT_W-1:0]  att_ff, att_in;
   logic              sync_ff, sync_in;

   // Captured digits, one nibble per digit position of the line
   logic [SLOT_W-1:0] digit_ff [DIGIT_SLOTS];

   // Output register
   logic              rsp_valid_ff;
   logic              echo_valid_ff, echo_valid_in;
   logic [BYTE_W-1:0] echo_byte_ff, echo_byte_in;
   logic              frame_valid_ff, frame_valid_in;
   logic              failed_ff, failed_in;
   logic [NUM_W-1:0]  year_ff, year_in;
   logic [NUM_W-1:0]  month_ff, month_in;
   logic [NUM_W-1:0]  day_ff, day_in;
   logic [NUM_W-1:0]  hour_ff, hour_in;
   logic [NUM_W-1:0]  minute_ff, minute_in;
   logic [NUM_W-1:0]  second_ff, second_in;
   logic              dst_ff, dst_in;
   logic              synced_ff, synced_in;

   logic              accept;
   logic [BYTE_W-1:0] rx;
   logic [BYTE_W-1:0] tch;
   logic              is_digit;
   logic              col_ok;
   slot_sel_type      slot;
   logic              end_att;
   logic              end_ok;
   logic [ATT_W-1:0]  att_dec;
   logic [NUM_W-1:0]  hour_val;
   logic [NUM_W-1:0]  dst_code;
   logic signed [8:0] local_hour;
   logic              dst_on;

   // The output register drains in the same cycle it refills
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rx             = req_chan.rx_byte;

   // Template check for the current column
   assign tch      = tmpl_char(col_ff);
   assign is_digit = (rx >= CH_ZERO) && (rx <= CH_NINE);
   assign slot     = digit_slot(col_ff);

   always_comb begin
      if (col_ff == LAST_COL) begin
         col_ok = (rx == CH_STAR) || (rx == CH_HASH);
      end else if (tch == CH_HASH) begin
         col_ok = is_digit;
      end else if (tch == CH_PLUS) begin
         col_ok = (rx == CH_PLUS) || (rx == CH_MINUS);
      end else begin
         col_ok = (rx == tch);
      end
   end

   // Date and time from the stored digits; the final byte writes no digit
   assign hour_val   = pair_val(digit_ff[6], digit_ff[7]);
   assign dst_code   = pair_val(digit_ff[12], digit_ff[13]);
   assign local_hour = $signed({2'b00, hour_val}) - $signed({{4{tz_west_ff[TZ_W-1]}}, tz_west_ff});

   always_comb begin
      if (dst_code == DST_OFF) begin
         dst_on = 1'b0;
      end else if (dst_code == DST_ALL_ON) begin
         dst_on = 1'b1;
      end else if (dst_code == DST_SPRING) begin
         dst_on = (local_hour >= 9'sd2);
      end else if (dst_code == DST_FALL) begin
         dst_on = (local_hour < 9'sd1);
      end else begin
         dst_on = (dst_code < DST_ALL_ON);
      end
   end

   // Next parse state and result for the byte on the input channel
   always_comb begin
      phase_in      = phase_ff;
      prog_in       = prog_ff;
      col_in        = col_ff;
      fcnt_in       = fcnt_ff;
      att_in        = att_ff;
      sync_in       = sync_ff;
      echo_valid_in = 1'b0;
      frame_valid_in = 1'b0;
      failed_in     = 1'b0;
      end_att       = 1'b0;
      end_ok        = 1'b0;
      att_dec       = (att_ff != '0) ? att_ff - 8'd1 : att_ff;

      unique case (phase_ff)
         PH_LINE: begin
            echo_valid_in = 1'b1;
            if ((col_ff == LAST_COL) && (rx == CH_HASH)) begin
               sync_in = 1'b1;
            end
            if (!col_ok) begin
               // A NUL at line start ends the attempt at once, no flush
               if ((col_ff == '0) && (rx == CH_NUL)) begin
                  end_att = 1'b1;
               end else begin
                  phase_in = PH_FLUSH;
                  fcnt_in  = '0;
               end
            end else if (col_ff == LAST_COL) begin
               end_att = 1'b1;
               end_ok  = 1'b1;
            end else begin
               col_in = col_ff + 6'd1;
            end
         end
         PH_FLUSH: begin
            // Echo up to the flush limit, then consume one byte silently
            if (fcnt_ff < FLUSH_MAX) begin
               echo_valid_in = 1'b1;
               fcnt_in       = fcnt_ff + 6'd1;
               end_att       = (rx == CH_STAR);
            end else begin
               end_att = 1'b1;
            end
         end
         PH_HUNT: begin
            if ((prog_ff == 2'd2) && (rx == CH_D)) begin
               prog_in = 2'd0;
               att_in  = max_att_ff;
               sync_in = 1'b0;
               if (max_att_ff == '0) begin
                  failed_in = 1'b1;
               end else begin
                  phase_in = PH_LINE;
                  col_in   = '0;
               end
            end else if ((prog_ff == 2'd1) && (rx == CH_J)) begin
               prog_in = 2'd2;
            end else if (rx == CH_M) begin
               prog_in = 2'd1;
            end else begin
               prog_in = 2'd0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            prog_in  = 2'd0;
         end
      endcase

      // Close the attempt: finish the run on sync or when attempts run out
      if (end_att) begin
         att_in = att_dec;
         if (sync_in || (att_dec == '0)) begin
            phase_in       = PH_HUNT;
            prog_in        = 2'd0;
            frame_valid_in = end_ok;
            failed_in      = !end_ok;
         end else begin
            phase_in = PH_LINE;
            col_in   = '0;
         end
      end
   end

   // Result payload; date fields stay zero unless the run ends valid
   always_comb begin
      echo_byte_in = echo_valid_in ? rx : '0;
      year_in      = '0;
      month_in     = '0;
      day_in       = '0;
      hour_in      = '0;
      minute_in    = '0;
      second_in    = '0;
      dst_in       = 1'b0;
      synced_in    = 1'b0;
      if (frame_valid_in) begin
         year_in   = pair_val(digit_ff[0], digit_ff[1]);
         month_in  = pair_val(digit_ff[2], digit_ff[3]);
         day_in    = pair_val(digit_ff[4], digit_ff[5]);
         hour_in   = hour_val;
         minute_in = pair_val(digit_ff[8], digit_ff[9]);
         second_in = pair_val(digit_ff[10], digit_ff[11]);
         dst_in    = dst_on;
         synced_in = sync_in;
      end
   end

   // Configuration writes; an index outside the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         tz_west_ff <= TZ_WEST_RST;
         max_att_ff <= MAX_ATTEMPTS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TZ_WEST:      tz_west_ff <= csr_wdata[TZ_W-1:0];
            CSR_MAX_ATTEMPTS: max_att_ff <= csr_wdata[ATT_W-1:0];
            default:          ;
         endcase
      end
   end

   // Capture a digit whenever its column matches the template
   always_ff @(posedge clock) begin
      if (accept && (phase_ff == PH_LINE) && col_ok && slot.hit) begin
         digit_ff[slot.idx] <= rx[SLOT_W-1:0];
      end
   end

   // Parse state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         prog_ff      <= 2'd0;
         col_ff       <= '0;
         fcnt_ff      <= '0;
         att_ff       <= MAX_ATTEMPTS_RST;
         sync_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            prog_ff        <= prog_in;
            col_ff         <= col_in;
            fcnt_ff        <= fcnt_in;
            att_ff         <= att_in;
            sync_ff        <= sync_in;
            rsp_valid_ff   <= 1'b1;
            echo_valid_ff  <= echo_valid_in;
            echo_byte_ff   <= echo_byte_in;
            frame_valid_ff <= frame_valid_in;
            failed_ff      <= failed_in;
            year_ff        <= year_in;
            month_ff       <= month_in;
            day_ff         <= day_in;
            hour_ff        <= hour_in;
            minute_ff      <= minute_in;
            second_ff      <= second_in;
            dst_ff         <= dst_in;
            synced_ff      <= synced_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.echo_valid  = echo_valid_ff;
   assign rsp_chan.echo_byte   = echo_byte_ff;
   assign rsp_chan.frame_valid = frame_valid_ff;
   assign rsp_chan.failed      = failed_ff;
   assign rsp_chan.year_2d     = year_ff;
   assign rsp_chan.month_num   = month_ff;
   assign rsp_chan.day_num     = day_ff;
   assign rsp_chan.hour_num    = hour_ff;
   assign rsp_chan.minute_num  = minute_ff;
   assign rsp_chan.second_num  = second_ff;
   assign rsp_chan.dst_active  = dst_ff;
   assign rsp_chan.synced      = synced_ff;

   // A run never ends both valid and failed
   a_end_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(frame_valid_ff && failed_ff))
      else $error("frame_valid and failed both set");

   // Bytes taken while hunting are never echoed
   a_hunt_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == PH_HUNT)) |=> !echo_valid_ff)
      else $error("echo during preamble hunt");

   // A valid finish comes from sync or from the last attempt
   a_finish_cause: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_valid_in) |=> (sync_ff || (att_ff == '0)))
      else $error("run finished without sync or exhausted attempts");

   // Flush and column counters stay within the line limits
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= LAST_COL) && (fcnt_ff <= FLUSH_MAX))
      else $error("line column or flush count out of range");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Time code line parser testbench
// Feeds received bytes through the request channel, predicts every response
// with a behavioral copy of the parser and compares them field by field.
// A short table of directed bytes and lines comes first. Random sessions
// with MJD literals, good lines, broken lines and flushes follow, under
// several idle/stall mixes and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;
   import tclp_pkg::*;

   // Parser phases as tracked by the prediction
   typedef enum logic [1:0] {
      HUNT_MJD,
      IN_LINE,
      FLUSHING
   } parse_phase_type;

   // One response transaction, in the same bit order as the port fields
   typedef struct packed {
      logic              echo_valid;
      logic [BYTE_W-1:0] echo_byte;
      logic              frame_valid;
      logic              failed;
      logic [NUM_W-1:0]  year_2d;
      logic [NUM_W-1:0]  month_num;
      logic [NUM_W-1:0]  day_num;
      logic [NUM_W-1:0]  hour_num;
      logic [NUM_W-1:0]  minute_num;
      logic [NUM_W-1:0]  second_num;
      logic              dst_active;
      logic              synced;
   } parse_result_type;

   // Kinds of directed rows: one byte, a register write, a whole line,
   // or a bad byte followed by a flush that never sees '*'
   typedef enum logic [2:0] {
      ROW_BYTE,
      ROW_TZ,
      ROW_ATT,
      ROW_LINE,
      ROW_FLUSH
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [BYTE_W-1:0] arg;     // byte, register value or line end mark
      logic [BYTE_W-1:0] fill;    // digit character for every line digit
      logic              typed;   // expected response given in the row
      logic              e_echo;
      logic              e_fail;
   } dir_row_type;

   localparam int RAND_ITEMS  = 1300;
   localparam int HOLD_CYCLES = 120;
   localparam int LONG_FLUSH  = 60;    // more than the flush can ever take
   localparam int NUM_DIR     = 24;

   localparam logic [LINE_LEN*BYTE_W-1:0] TIME_LINE =
      "\r\n##### ##-##-## ##:##:## ## # +.# ###.# UTC(NIST) *";

   localparam dir_row_type DIR_ROWS [NUM_DIR] = '{
      // zero attempts: the D that completes MJD fails the run, no echo
      '{ROW_ATT,  8'd0,     8'd0,    1'b0, 1'b0, 1'b0},
      '{ROW_BYTE, CH_M,     8'd0,    1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, CH_J,     8'd0,    1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, CH_D,     8'd0,    1'b1, 1'b0, 1'b1},
      // hunting bytes are never echoed
      '{ROW_BYTE, 8'hFF,    8'd0,    1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, CH_NUL,   8'd0,    1'b1, 1'b0, 1'b0},
      '{ROW_ATT,  8'd255,   8'd0,    1'b0, 1'b0, 1'b0},
      '{ROW_TZ,   8'hF4,    8'd0,    1'b0, 1'b0, 1'b0},
      // overlapping start of the literal
      '{ROW_BYTE, CH_M,     8'd0,    1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, CH_M,     8'd0,    1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, CH_J,     8'd0,    1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, CH_D,     8'd0,    1'b1, 1'b0, 1'b0},
      // zero byte at line start: echoed, attempt ends without a flush
      '{ROW_BYTE, CH_NUL,   8'd0,    1'b1, 1'b1, 1'b0},
      // mismatch in column 0, then '*' closes the flush
      '{ROW_BYTE, 8'hFF,    8'd0,    1'b1, 1'b1, 1'b0},
      '{ROW_BYTE, CH_STAR,  8'd0,    1'b1, 1'b1, 1'b0},
      // flush limit: 54 echoed, the 55th swallowed
      '{ROW_FLUSH, 8'h80,   8'd0,    1'b0, 1'b0, 1'b0},
      // sync line with every digit at 9
      '{ROW_LINE, CH_HASH,  CH_NINE, 1'b0, 1'b0, 1'b0},
      '{ROW_ATT,  8'd1,     8'd0,    1'b0, 1'b0, 1'b0},
      '{ROW_TZ,   8'h0C,    8'd0,    1'b0, 1'b0, 1'b0},
      '{ROW_BYTE, CH_M,     8'd0,    1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, CH_J,     8'd0,    1'b1, 1'b0, 1'b0},
      '{ROW_BYTE, CH_D,     8'd0,    1'b1, 1'b0, 1'b0},
      // last attempt used up on a good unsynced line with every digit at 0
      '{ROW_LINE, CH_STAR,  CH_ZERO, 1'b0, 1'b0, 1'b0},
      // back to hunting after the run
      '{ROW_BYTE, CH_PLUS,  8'd0,    1'b1, 1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tclp_req_if req_bus ();
   tclp_rsp_if rsp_bus ();

   time_code_line_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ----- prediction state, at its reset values ----------------------------
   parse_phase_type  phase_now  = HUNT_MJD;
   int               mjd_prog   = 0;
   int               line_col   = 0;
   int               flush_cnt  = 0;
   logic [ATT_W-1:0] att_left   = MAX_ATTEMPTS_RST;
   bit               sync_seen  = 1'b0;
   logic [3:0]       digits [DIGIT_SLOTS];
   int               tz_west    = 0;
   logic [ATT_W-1:0] max_att    = MAX_ATTEMPTS_RST;
   parse_result_type step_out;

   // ----- bookkeeping ------------------------------------------------------
   parse_result_type results_due [$];
   parse_result_type seen_rsp, due_rsp;
   int bytes_sent   = 0;
   int fail_cnt     = 0;
   int echoes       = 0;
   int frames_ok    = 0;
   int frames_sync  = 0;
   int runs_failed  = 0;
   int csr_writes   = 0;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int holds_asked  = 0;
   int hold_left    = 0;
   int holds_done   = 0;

   // ----- prediction -------------------------------------------------------
   function automatic logic [BYTE_W-1:0] line_char(input int col);
      return TIME_LINE[(LINE_LEN - 1 - col) * BYTE_W +: BYTE_W];
   endfunction

   function automatic bit col_matches(input int col, input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] t;
      t = line_char(col);
      if (col == LINE_LEN - 1) return (b == CH_STAR) || (b == CH_HASH);
      if (t == CH_HASH) return (b >= CH_ZERO) && (b <= CH_NINE);
      if (t == CH_PLUS) return (b == CH_PLUS) || (b == CH_MINUS);
      return b == t;
   endfunction

   // Digit columns come in pairs from column 8 to 27, one separator between
   function automatic int slot_of(input int col);
      if (col < 8 || col > 27 || (col - 8) % 3 == 2) return -1;
      return ((col - 8) / 3) * 2 + (col - 8) % 3;
   endfunction

   function automatic int two_digits(input int k);
      return int'(digits[2*k]) * 10 + int'(digits[2*k+1]);
   endfunction

   function automatic void finish_run(input bit good);
      int hour, code, h;
      bit on;
      phase_now = HUNT_MJD;
      mjd_prog  = 0;
      if (!good) begin
         step_out.failed = 1'b1;
         return;
      end
      hour = two_digits(3);
      code = two_digits(6);
      h    = hour - tz_west;
      if (code == 0)               on = 1'b0;
      else if (code == DST_ALL_ON) on = 1'b1;
      else if (code == DST_SPRING) on = (h >= 2);
      else if (code == DST_FALL)   on = (h < 1);
      else                         on = (code <= DST_ALL_ON);
      step_out.frame_valid = 1'b1;
      step_out.year_2d     = NUM_W'(two_digits(0));
      step_out.month_num   = NUM_W'(two_digits(1));
      step_out.day_num     = NUM_W'(two_digits(2));
      step_out.hour_num    = NUM_W'(hour);
      step_out.minute_num  = NUM_W'(two_digits(4));
      step_out.second_num  = NUM_W'(two_digits(5));
      step_out.dst_active  = on;
      step_out.synced      = sync_seen;
   endfunction

   function automatic void close_attempt(input bit good);
      if (att_left > 0) att_left = att_left - 1'b1;
      if (sync_seen || att_left == 0) begin
         finish_run(good);
      end else begin
         phase_now = IN_LINE;
         line_col  = 0;
      end
   endfunction

   task automatic decode_byte(input logic [BYTE_W-1:0] b, output parse_result_type r);
      int slot;
      bit ok;
      step_out = '0;
      case (phase_now)
         IN_LINE: begin
            step_out.echo_valid = 1'b1;
            step_out.echo_byte  = b;
            ok   = col_matches(line_col, b);
            slot = slot_of(line_col);
            if (ok && slot >= 0) digits[slot] = 4'(b - CH_ZERO);
            if (line_col == LINE_LEN - 1 && b == CH_HASH) sync_seen = 1'b1;
            if (!ok) begin
               if (line_col == 0 && b == CH_NUL) begin
                  close_attempt(1'b0);
               end else begin
                  phase_now = FLUSHING;
                  flush_cnt = 0;
               end
            end else if (line_col == LINE_LEN - 1) begin
               close_attempt(1'b1);
            end else begin
               line_col++;
            end
         end
         FLUSHING: begin
            if (flush_cnt < FLUSH_ECHO_MAX) begin
               step_out.echo_valid = 1'b1;
               step_out.echo_byte  = b;
               flush_cnt++;
               if (b == CH_STAR) close_attempt(1'b0);
            end else begin
               close_attempt(1'b0);
            end
         end
         default: begin
            if (mjd_prog == 2 && b == CH_D) begin
               mjd_prog  = 0;
               att_left  = max_att;
               sync_seen = 1'b0;
               if (att_left == 0) begin
                  finish_run(1'b0);
               end else begin
                  phase_now = IN_LINE;
                  line_col  = 0;
               end
            end else if (mjd_prog == 1 && b == CH_J) begin
               mjd_prog = 2;
            end else if (b == CH_M) begin
               mjd_prog = 1;
            end else begin
               mjd_prog = 0;
            end
         end
      endcase
      r = step_out;
   endtask

   // ----- request side -----------------------------------------------------
   // Offer one byte, hold it until accepted, then queue its expected response
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                            input parse_result_type want = '0);
      parse_result_type r;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      decode_byte(b, r);
      results_due.push_back(typed ? want : r);
      bytes_sent++;
   endtask

   // Send a line from the template; stop after a bad byte at break_col
   task automatic send_line(input logic [BYTE_W-1:0] mark, input logic [BYTE_W-1:0] fill,
                            input int break_col);
      logic [BYTE_W-1:0] b, t, d_hi, d_lo;
      int pick;
      // bias the DST pair toward the codes with their own rule
      pick = $urandom_range(0, 4);
      d_hi = (pick == 1 || pick == 2) ? CH_ZERO + 8'd5 : CH_ZERO;
      d_lo = (pick == 2 || pick == 3) ? CH_ZERO + 8'd1 : CH_ZERO;
      if (pick == 4) begin
         d_hi = CH_ZERO + 8'($urandom_range(0, 9));
         d_lo = CH_ZERO + 8'($urandom_range(0, 9));
      end
      for (int c = 0; c < LINE_LEN; c++) begin
         if (c == break_col) begin
            do b = 8'($urandom_range(0, 255)); while (col_matches(c, b));
            send_byte(b);
            return;
         end
         t = line_char(c);
         if (c == LINE_LEN - 1)     b = mark;
         else if (t == CH_HASH) begin
            if (fill != 0)          b = fill;
            else if (c == 26)       b = d_hi;
            else if (c == 27)       b = d_lo;
            else                    b = CH_ZERO + 8'($urandom_range(0, 9));
         end
         else if (t == CH_PLUS)     b = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
         else                       b = t;
         send_byte(b);
      end
   endtask

   // Keep feeding non-'*' bytes while flushing; '*' goes after plan of them
   task automatic flush_through(input int plan);
      logic [BYTE_W-1:0] b;
      int n;
      n = 0;
      while (phase_now == FLUSHING) begin
         if (n == plan) b = CH_STAR;
         else do b = 8'($urandom_range(0, 255)); while (b == CH_STAR);
         send_byte(b);
         n++;
      end
   endtask

   // Registers change only with nothing in flight
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      req_bus.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TZ_WEST) tz_west = int'($signed(data[TZ_W-1:0]));
      else                    max_att = data;
      csr_writes++;
   endtask

   task automatic retune_config();
      int pick;
      logic [CSR_DATA_W-1:0] v;
      write_csr(CSR_TZ_WEST, 8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 9);
      case (pick)
         0:       v = 8'd0;
         1:       v = 8'd255;
         2:       v = MAX_ATTEMPTS_RST;
         3:       v = 8'($urandom_range(0, 255));
         default: v = 8'($urandom_range(1, 4));
      endcase
      write_csr(CSR_MAX_ATTEMPTS, v);
   endtask

   // One session: noise, the MJD literal, then a handful of line attempts
   task automatic run_session();
      int n, lines, pick;
      logic [BYTE_W-1:0] mark;
      n = $urandom_range(0, 5);
      repeat (n) begin
         pick = $urandom_range(0, 3);
         send_byte(pick == 0 ? CH_M : pick == 1 ? CH_J : 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 7) == 0) begin
         send_byte(CH_M);
         send_byte(CH_J);
         send_byte(8'($urandom_range(0, 255)));
      end
      send_byte(CH_M);
      send_byte(CH_J);
      send_byte(CH_D);
      lines = 0;
      while (phase_now != HUNT_MJD && lines < 6) begin
         lines++;
         pick = $urandom_range(0, 99);
         mark = ($urandom_range(0, 3) == 0) ? CH_HASH : CH_STAR;
         if (pick < 55) begin
            send_line(mark, 8'd0, -1);
         end else if (pick < 63) begin
            send_byte(CH_NUL);
         end else begin
            send_line(mark, 8'd0, $urandom_range(0, LINE_LEN - 1));
            if (pick < 80)      flush_through($urandom_range(0, 8));
            else if (pick < 90) flush_through(LONG_FLUSH);
            else                flush_through(FLUSH_ECHO_MAX - 1);
         end
      end
   endtask

   // ----- response side ----------------------------------------------------
   // Drop ready at random; serve a requested hold-off as one long stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_done != holds_asked) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   function automatic string show_result(input parse_result_type r);
      return {$sformatf("echo=%0b/%02h frame=%0b fail=%0b ",
                        r.echo_valid, r.echo_byte, r.frame_valid, r.failed),
              $sformatf("ymd=%0d-%0d-%0d hms=%0d:%0d:%0d dst=%0b sync=%0b",
                        r.year_2d, r.month_num, r.day_num, r.hour_num,
                        r.minute_num, r.second_num, r.dst_active, r.synced)};
   endfunction

   // Compare every accepted response transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_rsp = {rsp_bus.echo_valid, rsp_bus.echo_byte, rsp_bus.frame_valid,
                     rsp_bus.failed, rsp_bus.year_2d, rsp_bus.month_num, rsp_bus.day_num,
                     rsp_bus.hour_num, rsp_bus.minute_num, rsp_bus.second_num,
                     rsp_bus.dst_active, rsp_bus.synced};
         if (results_due.size() == 0) begin
            if (fail_cnt < 10) $display("ERROR: response with nothing due: %s",
                                        show_result(seen_rsp));
            fail_cnt++;
         end else begin
            due_rsp = results_due.pop_front();
            if (seen_rsp !== due_rsp) begin
               if (fail_cnt < 10) begin
                  $display("ERROR at %0t: response mismatch", $realtime);
                  $display("   expected %s", show_result(due_rsp));
                  $display("   actual   %s", show_result(seen_rsp));
               end
               fail_cnt++;
            end
         end
         echoes      += seen_rsp.echo_valid;
         frames_ok   += seen_rsp.frame_valid;
         frames_sync += seen_rsp.frame_valid & seen_rsp.synced;
         runs_failed += seen_rsp.failed;
      end
   end

   // ----- main sequence ----------------------------------------------------
   initial begin
      dir_row_type      row;
      parse_result_type want;
      int               base;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_TZ_WEST;
      csr_wdata       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed rows with no idling on either side
      for (int i = 0; i < NUM_DIR; i++) begin
         row = DIR_ROWS[i];
         case (row.kind)
            ROW_TZ:    write_csr(CSR_TZ_WEST, row.arg);
            ROW_ATT:   write_csr(CSR_MAX_ATTEMPTS, row.arg);
            ROW_LINE:  send_line(row.arg, row.fill, -1);
            ROW_FLUSH: begin
               send_byte(row.arg);
               flush_through(LONG_FLUSH);
            end
            default: begin
               want            = '0;
               want.echo_valid = row.e_echo;
               want.echo_byte  = row.e_echo ? row.arg : 8'd0;
               want.failed     = row.e_fail;
               send_byte(row.arg, row.typed, want);
            end
         endcase
      end

      // Random sessions; hold the response side off once early so the
      // output register fills and the request side backs up
      base = bytes_sent;
      holds_asked++;
      while (bytes_sent - base < RAND_ITEMS) begin
         case ((bytes_sent - base) * 4 / RAND_ITEMS)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 51; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         if ($urandom_range(0, 1) == 0) retune_config();
         run_session();
      end

      // Drain, then allow for the output register
      req_bus.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d bytes over %0d register writes; %0d echoed.",
               bytes_sent, csr_writes, echoes);
      $display("Runs ended: %0d with a good line (%0d synced), %0d failed.",
               frames_ok, frames_sync, runs_failed);
      if (fail_cnt == 0 && results_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
